[src/hts_pkg.sv]
// shared types, character codes and helpers for the hex tag stream loader
`timescale 1ns / 1ps
package hts_pkg;

  // stream characters
  localparam logic [7:0] CH_OPEN  = 8'h3C;  // '<'
  localparam logic [7:0] CH_CLOSE = 8'h3E;  // '>'
  localparam logic [7:0] CH_SLASH = 8'h2F;  // '/'

  // tag names, left justified, first character in the top byte
  localparam logic [63:0] NAME_ERASE = {"SetAddr", 8'h00};
  localparam logic [63:0] NAME_PROG  = "MemProgC";
  localparam logic [63:0] NAME_RUN   = {"Run", 40'h0};
  localparam logic [3:0]  LEN_ERASE  = 4'd7;
  localparam logic [3:0]  LEN_PROG   = 4'd8;
  localparam logic [3:0]  LEN_RUN    = 4'd3;

  // event codes
  localparam logic [1:0] EV_NONE  = 2'd0;
  localparam logic [1:0] EV_ERASE = 2'd1;
  localparam logic [1:0] EV_BYTE  = 2'd2;
  localparam logic [1:0] EV_RUN   = 2'd3;

  // status codes
  localparam logic [2:0] ST_BUSY     = 3'd0;
  localparam logic [2:0] ST_DONE     = 3'd1;
  localparam logic [2:0] ST_OVERFLOW = 3'd2;
  localparam logic [2:0] ST_FORMAT   = 3'd3;
  localparam logic [2:0] ST_BADCHAR  = 3'd4;

  // result word: event in the low two bits, then the 40-bit data part
  localparam int OUT_W = 42;

  // one queued command: a single result, or a packet burst read from the store
  typedef struct packed {
    logic        burst;
    logic [1:0]  ev;
    logic [2:0]  status;
    logic [6:0]  nbytes;
    logic [15:0] pnum;
  } cmd_t;

  function automatic logic [7:0] name_char(logic [63:0] name, logic [2:0] idx);
    logic [2:0] r;
    r = 3'd7 - idx;
    return name[{r, 3'b000} +: 8];
  endfunction

  // {not_hex, nibble}
  function automatic logic [4:0] hex_nib(logic [7:0] c);
    logic [4:0] v;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = {1'b0, 4'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = {1'b0, 4'(c - 8'h37)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = {1'b0, 4'(c - 8'h57)};
    end else begin
      v = 5'h10;
    end
    return v;
  endfunction

  function automatic logic [OUT_W-1:0] pack_result(logic [1:0] ev, logic [7:0] bval,
                                                   logic [6:0] nb, logic [15:0] pnum,
                                                   logic [2:0] st);
    return {6'b000000, st, pnum, nb, bval, ev};
  endfunction

endpackage

[src/hex_tag_stream_loader.sv]
// top level of the hex tag stream loader: front end, command queue, back end
//
//   channel  dir  tdata                               tlast          tuser
//   s_*      in   [7:0] in_char                       -              -
//   m_*      out  byte_value, packet_bytes,           last result    event_res
//                 packet_number, status (40 bits)     of a character
//
// - the front end takes one character per cycle and pushes exactly one command
//   per character into a four-entry queue; s_tready drops while the queue is full
// - a packet flush of n bytes holds the input until the back end has read all n
//   bytes out of the byte store, with one store read and one output load per
//   byte; other characters pass at one per cycle while the queue has room
// - results leave through an output register, so a stalled m_tready only backs
//   up into the queue and the front end keeps taking characters until it fills
// - rst is synchronous and active high; the byte store needs no clearing pass,
//   only bytes written since the last flush are ever read
`timescale 1ns / 1ps
module hex_tag_stream_loader #(
  parameter int BUFFER_CHARS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_char
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [7:0] byte_value, [14:8] packet_bytes,
                                 // [30:15] packet_number, [33:31] status,
                                 // [39:34] zero
  output logic [1:0]  m_tuser,   // [1:0] event_res
  output logic        m_tlast    // last result of the character
);

  localparam int DEPTH = (BUFFER_CHARS / 2 > 1) ? BUFFER_CHARS / 2 : 1;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // front to queue
  logic          push, q_full;
  hts_pkg::cmd_t push_cmd;

  // queue to back
  logic          q_valid, q_pop;
  hts_pkg::cmd_t q_cmd;

  // byte store write port and burst completion
  logic          wr_en, burst_done;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;

  // result word: event in the low bits, data part above
  logic [hts_pkg::OUT_W-1:0] out_word;

  assign m_tuser = out_word[1:0];
  assign m_tdata = out_word[41:2];

  hts_front #(
    .BUFFER_CHARS(BUFFER_CHARS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_char   (s_tdata),
    .q_full    (q_full),
    .push      (push),
    .cmd       (push_cmd),
    .burst_done(burst_done),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  hts_fifo u_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .din  (push_cmd),
    .full (q_full),
    .pop  (q_pop),
    .dout (q_cmd),
    .valid(q_valid)
  );

  hts_back #(
    .BUFFER_CHARS(BUFFER_CHARS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .burst_done(burst_done),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_word),
    .out_last  (m_tlast)
  );

endmodule

[src/hts_front.sv]
// front end: character classification, tag matching and packet fill
`timescale 1ns / 1ps
module hts_front #(
  parameter int BUFFER_CHARS = 64,
  localparam int FW    = $clog2(BUFFER_CHARS + 1),
  localparam int DEPTH = (BUFFER_CHARS / 2 > 1) ? BUFFER_CHARS / 2 : 1,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [7:0]     in_char,
  input  logic           q_full,
  output logic           push,
  output hts_pkg::cmd_t  cmd,
  input  logic           burst_done,
  output logic           wr_en,
  output logic [AW-1:0]  wr_addr,
  output logic [7:0]     wr_data
);

  typedef enum logic [3:0] {
    M_IDLE = 4'b0001,
    M_TAG  = 4'b0010,
    M_DATA = 4'b0100,
    M_DONE = 4'b1000
  } mode_t;

  mode_t         mode, mode_next;
  logic [FW-1:0] fill, fill_next, fill_d;
  logic [15:0]   packets, packets_next, packets_inc;
  logic [3:0]    hi, hi_next;
  logic          bad, bad_next, bad_d;
  logic          m_erase, m_prog, m_run;
  logic          m_erase_next, m_prog_next, m_run_next;
  logic          burst_out;
  logic          accept, full, open_c, close_c, flush, we_c;
  logic [7:0]    fill_ext;
  logic [4:0]    hx;

  assign in_ready    = !burst_out && !q_full;
  assign accept      = in_valid && in_ready;
  assign push        = accept;
  assign fill_ext    = 8'(fill);
  assign full        = (fill >= FW'(BUFFER_CHARS));
  assign open_c      = (in_char == hts_pkg::CH_OPEN);
  assign close_c     = (in_char == hts_pkg::CH_CLOSE) || (in_char == hts_pkg::CH_SLASH);
  assign hx          = hts_pkg::hex_nib(in_char);
  assign packets_inc = (packets == 16'hFFFF) ? packets : packets + 16'd1;
  assign wr_en       = we_c && accept;
  assign wr_addr     = AW'(fill >> 1);
  assign wr_data     = {hi, hx[3:0]};

  always_comb begin
    mode_next    = mode;
    fill_next    = fill;
    packets_next = packets;
    hi_next      = hi;
    bad_next     = bad;
    m_erase_next = m_erase;
    m_prog_next  = m_prog;
    m_run_next   = m_run;
    we_c         = 1'b0;
    fill_d       = fill;
    bad_d        = bad;
    flush        = 1'b0;
    cmd          = '{burst: 1'b0, ev: hts_pkg::EV_NONE, status: hts_pkg::ST_BUSY,
                     nbytes: 7'd0, pnum: packets};
    unique case (mode)
      M_IDLE: begin
        if (open_c) begin
          mode_next    = M_TAG;
          fill_next    = '0;
          m_erase_next = 1'b1;
          m_prog_next  = 1'b1;
          m_run_next   = 1'b1;
        end
      end
      M_TAG: begin
        if (close_c) begin
          if (full) begin
            cmd.status = hts_pkg::ST_OVERFLOW;
          end else begin
            mode_next = M_IDLE;
            if (m_erase && fill_ext == {4'd0, hts_pkg::LEN_ERASE}) begin
              cmd.ev = hts_pkg::EV_ERASE;
            end else if (m_prog && fill_ext == {4'd0, hts_pkg::LEN_PROG}) begin
              mode_next    = M_DATA;
              fill_next    = '0;
              packets_next = 16'd0;
              bad_next     = 1'b0;
              cmd.pnum     = 16'd0;
            end else if (m_run && fill_ext == {4'd0, hts_pkg::LEN_RUN}) begin
              mode_next  = M_DONE;
              cmd.ev     = hts_pkg::EV_RUN;
              cmd.status = hts_pkg::ST_DONE;
            end
          end
        end else if (full) begin
          cmd.status = hts_pkg::ST_OVERFLOW;
        end else begin
          // running prefix match against each tag name
          fill_next    = fill + 1'b1;
          m_erase_next = m_erase && (fill_ext < {4'd0, hts_pkg::LEN_ERASE}) &&
                         (in_char == hts_pkg::name_char(hts_pkg::NAME_ERASE, fill_ext[2:0]));
          m_prog_next  = m_prog && (fill_ext < {4'd0, hts_pkg::LEN_PROG}) &&
                         (in_char == hts_pkg::name_char(hts_pkg::NAME_PROG, fill_ext[2:0]));
          m_run_next   = m_run && (fill_ext < {4'd0, hts_pkg::LEN_RUN}) &&
                         (in_char == hts_pkg::name_char(hts_pkg::NAME_RUN, fill_ext[2:0]));
        end
      end
      M_DATA: begin
        if (!open_c && !full) begin
          fill_d = fill + 1'b1;
          bad_d  = bad | hx[4];
          // even positions hold the high nibble, odd positions write the byte
          if (!fill[0]) begin
            hi_next = hx[3:0];
          end else begin
            we_c = 1'b1;
          end
        end
        flush     = open_c || (fill_d >= FW'(BUFFER_CHARS));
        fill_next = fill_d;
        bad_next  = bad_d;
        if (flush) begin
          if (fill_d[0]) begin
            cmd.status = hts_pkg::ST_FORMAT;
          end else if (bad_d) begin
            cmd.status = hts_pkg::ST_BADCHAR;
          end else begin
            packets_next = packets_inc;
            cmd.pnum     = packets_inc;
            cmd.nbytes   = 7'(fill_d >> 1);
            if (cmd.nbytes != 7'd0) begin
              cmd.burst = 1'b1;
              cmd.ev    = hts_pkg::EV_BYTE;
            end
            fill_next = '0;
            bad_next  = 1'b0;
            if (open_c) begin
              mode_next = M_IDLE;
            end
          end
        end
      end
      M_DONE: begin
        cmd.status = hts_pkg::ST_FORMAT;
      end
      default: begin
        mode_next = M_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= M_IDLE;
      fill      <= '0;
      packets   <= 16'd0;
      bad       <= 1'b0;
      m_erase   <= 1'b0;
      m_prog    <= 1'b0;
      m_run     <= 1'b0;
      burst_out <= 1'b0;
    end else begin
      if (accept) begin
        mode    <= mode_next;
        fill    <= fill_next;
        packets <= packets_next;
        bad     <= bad_next;
        m_erase <= m_erase_next;
        m_prog  <= m_prog_next;
        m_run   <= m_run_next;
      end
      if (accept && cmd.burst) begin
        burst_out <= 1'b1;
      end else if (burst_done) begin
        burst_out <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hi <= hi_next;
    end
  end

endmodule

[src/hts_fifo.sv]
// four-entry command queue between front and back
`timescale 1ns / 1ps
module hts_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  hts_pkg::cmd_t din,
  output logic          full,
  input  logic          pop,
  output hts_pkg::cmd_t dout,
  output logic          valid
);

  hts_pkg::cmd_t entry [4];
  logic [1:0]    wptr, rptr;
  logic [2:0]    count;

  assign full  = (count == 3'd4);
  assign valid = (count != 3'd0);
  assign dout  = entry[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 2'd0;
      rptr  <= 2'd0;
      count <= 3'd0;
    end else begin
      if (push) begin
        wptr <= wptr + 2'd1;
      end
      if (pop) begin
        rptr <= rptr + 2'd1;
      end
      if (push && !pop) begin
        count <= count + 3'd1;
      end else if (pop && !push) begin
        count <= count - 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wptr] <= din;
    end
  end

endmodule

[src/hts_back.sv]
// back end: packet byte store, burst readout and output register
`timescale 1ns / 1ps
module hts_back #(
  parameter int BUFFER_CHARS = 64,
  localparam int DEPTH = (BUFFER_CHARS / 2 > 1) ? BUFFER_CHARS / 2 : 1,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      q_valid,
  input  hts_pkg::cmd_t             q_cmd,
  output logic                      q_pop,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic [7:0]                wr_data,
  output logic                      burst_done,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [hts_pkg::OUT_W-1:0] out_data,
  output logic                      out_last
);

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_READ = 3'b010,
    B_EMIT = 3'b100
  } bstate_t;

  bstate_t                   state, state_next;
  logic [7:0]                mem [DEPTH];
  logic [7:0]                rd_data;
  logic [AW-1:0]             raddr, raddr_next;
  logic [6:0]                left, left_next;
  logic [6:0]                nbytes, nbytes_next;
  logic [15:0]               pnum, pnum_next;
  logic                      out_free, load, ld_last;
  logic [hts_pkg::OUT_W-1:0] ld_data;

  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next  = state;
    raddr_next  = raddr;
    left_next   = left;
    nbytes_next = nbytes;
    pnum_next   = pnum;
    q_pop       = 1'b0;
    load        = 1'b0;
    ld_last     = 1'b1;
    burst_done  = 1'b0;
    ld_data     = hts_pkg::pack_result(q_cmd.ev, 8'd0, 7'd0, q_cmd.pnum, q_cmd.status);
    unique case (state)
      B_IDLE: begin
        if (q_valid) begin
          if (q_cmd.burst) begin
            q_pop       = 1'b1;
            left_next   = q_cmd.nbytes;
            nbytes_next = q_cmd.nbytes;
            pnum_next   = q_cmd.pnum;
            raddr_next  = '0;
            state_next  = B_READ;
          end else if (out_free) begin
            q_pop = 1'b1;
            load  = 1'b1;
          end
        end
      end
      B_READ: begin
        state_next = B_EMIT;
      end
      B_EMIT: begin
        if (out_free) begin
          load    = 1'b1;
          ld_data = hts_pkg::pack_result(hts_pkg::EV_BYTE, rd_data, nbytes, pnum,
                                         hts_pkg::ST_BUSY);
          ld_last = (left == 7'd1);
          if (left == 7'd1) begin
            burst_done = 1'b1;
            state_next = B_IDLE;
          end else begin
            left_next  = left - 7'd1;
            raddr_next = raddr + 1'b1;
            state_next = B_READ;
          end
        end
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    raddr  <= raddr_next;
    left   <= left_next;
    nbytes <= nbytes_next;
    pnum   <= pnum_next;
    if (load) begin
      out_data <= ld_data;
      out_last <= ld_last;
    end
  end

endmodule

[tb/hts_checker.sv]
// checker for the hex tag stream loader: predicts every result transaction and compares it
`timescale 1ns / 1ps
module hts_checker #(
  parameter int BUFFER_CHARS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [39:0] m_tdata,
  input  logic [1:0]  m_tuser,
  input  logic        m_tlast,
  output int          fail_count,
  output int          pending
);

  typedef enum logic [3:0] {
    LD_IDLE = 4'b0001,
    LD_TAG  = 4'b0010,
    LD_DATA = 4'b0100,
    LD_DONE = 4'b1000
  } loader_mode_t;

  typedef struct packed {
    logic [1:0]  ev;
    logic [7:0]  bval;
    logic [6:0]  nbytes;
    logic [15:0] pnum;
    logic [2:0]  status;
    logic        is_last;
  } loader_result_t;

  loader_mode_t   mode;
  logic [7:0]     char_buf [BUFFER_CHARS];
  int             fill;
  logic [15:0]    packets_sent;
  loader_result_t loader_out_q [$];

  // {not_hex, nibble}
  function automatic logic [4:0] hex_digit(logic [7:0] c);
    if (c >= "0" && c <= "9") return {1'b0, 4'(c - "0")};
    if (c >= "A" && c <= "F") return {1'b0, 4'(c - "A" + 8'd10)};
    if (c >= "a" && c <= "f") return {1'b0, 4'(c - "a" + 8'd10)};
    return 5'h10;
  endfunction

  function automatic bit tag_is(string nm);
    if (fill != nm.len()) return 1'b0;
    for (int i = 0; i < fill; i++) begin
      if (char_buf[i] != nm[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void emit(logic [1:0] ev, logic [7:0] bval, logic [6:0] nb,
                               logic [2:0] st, logic is_last);
    loader_out_q.push_back('{ev, bval, nb, packets_sent, st, is_last});
  endfunction

  // one character in, its results queued in order
  function automatic void loader_step(logic [7:0] ch);
    bit          opening;
    bit          bad;
    int          nbytes;
    logic [4:0]  hi;
    logic [4:0]  lo;
    case (mode)
      LD_IDLE: begin
        if (ch == hts_pkg::CH_OPEN) begin
          mode = LD_TAG;
          fill = 0;
        end
        emit(hts_pkg::EV_NONE, 8'h00, 7'd0, hts_pkg::ST_BUSY, 1'b1);
      end
      LD_TAG: begin
        if (ch == hts_pkg::CH_CLOSE || ch == hts_pkg::CH_SLASH) begin
          if (fill >= BUFFER_CHARS) begin
            emit(hts_pkg::EV_NONE, 8'h00, 7'd0, hts_pkg::ST_OVERFLOW, 1'b1);
          end else begin
            mode = LD_IDLE;
            if (tag_is("SetAddr")) begin
              emit(hts_pkg::EV_ERASE, 8'h00, 7'd0, hts_pkg::ST_BUSY, 1'b1);
            end else if (tag_is("MemProgC")) begin
              mode = LD_DATA;
              fill = 0;
              packets_sent = '0;
              emit(hts_pkg::EV_NONE, 8'h00, 7'd0, hts_pkg::ST_BUSY, 1'b1);
            end else if (tag_is("Run")) begin
              mode = LD_DONE;
              emit(hts_pkg::EV_RUN, 8'h00, 7'd0, hts_pkg::ST_DONE, 1'b1);
            end else begin
              emit(hts_pkg::EV_NONE, 8'h00, 7'd0, hts_pkg::ST_BUSY, 1'b1);
            end
          end
        end else if (fill >= BUFFER_CHARS) begin
          emit(hts_pkg::EV_NONE, 8'h00, 7'd0, hts_pkg::ST_OVERFLOW, 1'b1);
        end else begin
          char_buf[fill] = ch;
          fill++;
          emit(hts_pkg::EV_NONE, 8'h00, 7'd0, hts_pkg::ST_BUSY, 1'b1);
        end
      end
      LD_DATA: begin
        opening = (ch == hts_pkg::CH_OPEN);
        if (!opening && fill < BUFFER_CHARS) begin
          char_buf[fill] = ch;
          fill++;
        end
        if (fill >= BUFFER_CHARS || opening) begin
          bad = 1'b0;
          for (int i = 0; i < fill; i++) begin
            if (hex_digit(char_buf[i]) > 5'd15) bad = 1'b1;
          end
          if (fill % 2 != 0) begin
            emit(hts_pkg::EV_NONE, 8'h00, 7'd0, hts_pkg::ST_FORMAT, 1'b1);
          end else if (bad) begin
            emit(hts_pkg::EV_NONE, 8'h00, 7'd0, hts_pkg::ST_BADCHAR, 1'b1);
          end else begin
            if (packets_sent != 16'hFFFF) packets_sent++;
            nbytes = fill / 2;
            if (nbytes == 0) begin
              emit(hts_pkg::EV_NONE, 8'h00, 7'd0, hts_pkg::ST_BUSY, 1'b1);
            end
            for (int i = 0; i < nbytes; i++) begin
              hi = hex_digit(char_buf[2*i]);
              lo = hex_digit(char_buf[2*i+1]);
              emit(hts_pkg::EV_BYTE, {hi[3:0], lo[3:0]}, 7'(nbytes), hts_pkg::ST_BUSY,
                   i == nbytes - 1);
            end
            fill = 0;
            if (opening) mode = LD_IDLE;
          end
        end else begin
          emit(hts_pkg::EV_NONE, 8'h00, 7'd0, hts_pkg::ST_BUSY, 1'b1);
        end
      end
      default: begin
        emit(hts_pkg::EV_NONE, 8'h00, 7'd0, hts_pkg::ST_FORMAT, 1'b1);
      end
    endcase
  endfunction

  always @(posedge clk) begin : monitor
    loader_result_t want;
    bit             wrong;
    if (rst) begin
      mode         = LD_IDLE;
      fill         = 0;
      packets_sent = '0;
      fail_count   = 0;
      loader_out_q.delete();
    end else begin
      // results first: a result never belongs to a character taken at the same edge
      if (m_tvalid && m_tready) begin
        if (loader_out_q.size() == 0) begin
          if (fail_count < 10) begin
            $display("[%0t] unexpected result: tuser=%h tdata=%h tlast=%b", $realtime,
                     m_tuser, m_tdata, m_tlast);
          end
          fail_count++;
        end else begin
          want  = loader_out_q.pop_front();
          wrong = (m_tuser[1:0] != want.ev) || (m_tdata[7:0] != want.bval) ||
                  (m_tdata[14:8] != want.nbytes) || (m_tdata[30:15] != want.pnum) ||
                  (m_tdata[33:31] != want.status) || (m_tdata[39:34] != 6'h0) ||
                  (m_tlast != want.is_last);
          if (wrong) begin
            if (fail_count < 10) begin
              $display("[%0t] result mismatch: ev %0d/%0d byte %h/%h nbytes %0d/%0d",
                       $realtime, want.ev, m_tuser[1:0], want.bval, m_tdata[7:0],
                       want.nbytes, m_tdata[14:8]);
              $display("  pnum %0d/%0d status %0d/%0d pad 0/%h last %b/%b (want/got)",
                       want.pnum, m_tdata[30:15], want.status, m_tdata[33:31],
                       m_tdata[39:34], want.is_last, m_tlast);
            end
            fail_count++;
          end
        end
      end
      if (s_tvalid && s_tready) loader_step(s_tdata);
    end
    pending = loader_out_q.size();
  end

endmodule

[tb/tb.sv]
// testbench top for the hex tag stream loader: character stimulus, pacing and verdict
`timescale 1ns / 1ps
module tb;

  localparam int BUFFER_CHARS = 64;
  localparam int RANDOM_CHARS = 170;
  localparam int MAX_GAP      = 18;
  localparam int HOLD_AFTER   = 60;      // results taken before the long hold-off
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 160;     // longer than the largest packet flush
  localparam int CYCLE_LIMIT  = 400000;

  localparam logic [7:0] CH_ZERO    = "0";
  localparam logic [7:0] CH_UPPER_A = "A";
  localparam logic [7:0] CH_LOWER_A = "a";

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;

  int fail_count;
  int pending;
  int cycle_count;
  int counted_chars;
  int results_taken;
  bit tx_pace;
  bit rx_pace;
  bit hold_done;

  string near_miss [7] = '{"SetAdd", "SetAddrr", "setAddr", "Ru", "Runn", "MemProgc", ""};

  hex_tag_stream_loader #(.BUFFER_CHARS(BUFFER_CHARS)) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  hts_checker #(.BUFFER_CHARS(BUFFER_CHARS)) u_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop if the run hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // result side: random stalls, stretches without stalls, one long hold-off
  initial begin : result_sink
    int stall;
    m_tready <= 1'b0;
    rx_pace = 1'b1;
    do @(posedge clk); while (rst);
    forever begin
      if ($urandom_range(0, 24) == 0) rx_pace = !rx_pace;
      stall = rx_pace ? $urandom_range(0, MAX_GAP) : 0;
      if (!hold_done && results_taken >= HOLD_AFTER) begin
        // sender keeps going, queue fills and s_tready drops
        hold_done = 1'b1;
        stall = HOLD_CYCLES;
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      results_taken++;
    end
  end

  // one character transaction, with a random gap ahead of it
  task automatic send_char(input logic [7:0] ch);
    int gap;
    if ($urandom_range(0, 19) == 0) tx_pace = !tx_pace;
    gap = tx_pace ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= ch;
    do @(posedge clk); while (!s_tready);
    counted_chars++;
  endtask

  task automatic send_text(input string t);
    for (int i = 0; i < t.len(); i++) send_char(t[i]);
  endtask

  function automatic bit is_hex_char(logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
  endfunction

  function automatic logic [7:0] rand_hex();
    case ($urandom_range(0, 2))
      0:       return CH_ZERO + 8'($urandom_range(0, 9));
      1:       return CH_UPPER_A + 8'($urandom_range(0, 5));
      default: return CH_LOWER_A + 8'($urandom_range(0, 5));
    endcase
  endfunction

  function automatic logic [7:0] pick_close();
    return ($urandom_range(0, 1) == 0) ? hts_pkg::CH_CLOSE : hts_pkg::CH_SLASH;
  endfunction

  // any character that does not close a tag
  function automatic logic [7:0] rand_tag_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (c == hts_pkg::CH_CLOSE || c == hts_pkg::CH_SLASH);
    return c;
  endfunction

  function automatic logic [7:0] rand_non_open();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == hts_pkg::CH_OPEN);
    return c;
  endfunction

  function automatic logic [7:0] rand_bad_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (is_hex_char(c) || c == hts_pkg::CH_OPEN);
    return c;
  endfunction

  task automatic send_hex(input int n);
    repeat (n) send_char(rand_hex());
  endtask

  task automatic tag_session(input string name, input logic [7:0] close_ch);
    send_char(hts_pkg::CH_OPEN);
    send_text(name);
    send_char(close_ch);
  endtask

  // enter data mode, optionally full packets, then one packet closed by '<'
  task automatic data_session();
    int full_packets;
    int len;
    tag_session("MemProgC", pick_close());
    full_packets = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2) : 0;
    repeat (full_packets) send_hex(BUFFER_CHARS);
    case ($urandom_range(0, 5))
      0: begin
        // odd count is rejected, one more digit makes it whole; 63 digits
        // plus one fill the buffer and the '<' then flushes an empty packet
        len = ($urandom_range(0, 3) == 0) ? BUFFER_CHARS - 1 : 2 * $urandom_range(0, 8) + 1;
        send_hex(len);
        send_char(hts_pkg::CH_OPEN);
        send_hex(1);
        send_char(hts_pkg::CH_OPEN);
      end
      1: send_char(hts_pkg::CH_OPEN);
      default: begin
        send_hex(2 * $urandom_range(1, 12));
        send_char(hts_pkg::CH_OPEN);
      end
    endcase
  endtask

  initial begin : stimulus
    int n;
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= 8'h00;
    tx_pace = 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: character extremes in idle, erase on '/', one packet of extreme bytes
    send_char(8'h00);
    send_char(8'hFF);
    tag_session("SetAddr", hts_pkg::CH_SLASH);
    tag_session("MemProgC", hts_pkg::CH_CLOSE);
    send_text("00fF9a");
    send_char(hts_pkg::CH_OPEN);

    // random: mostly well-formed sessions, some noise and near-miss tags
    counted_chars = 0;
    tag_session("MemProgC", pick_close());
    send_hex(BUFFER_CHARS);
    send_hex(2 * $urandom_range(0, 4));
    send_char(hts_pkg::CH_OPEN);
    while (counted_chars < RANDOM_CHARS) begin
      case ($urandom_range(0, 9))
        0: begin
          // ignored in idle, not counted
          n = $urandom_range(1, 3);
          repeat (n) send_char(rand_non_open());
          counted_chars -= n;
        end
        1: tag_session(near_miss[$urandom_range(0, 6)], pick_close());
        2: begin
          n = ($urandom_range(0, 4) == 0) ? BUFFER_CHARS - 1 : $urandom_range(0, 10);
          send_char(hts_pkg::CH_OPEN);
          repeat (n) send_char(rand_tag_char());
          send_char(pick_close());
        end
        3: tag_session("SetAddr", pick_close());
        default: data_session();
      endcase
    end

    // every ending below locks the loader until reset, so only one per run
    case ($urandom_range(0, 2))
      0: tag_session("Run", pick_close());
      1: begin
        // tag overflow, then a close on the full buffer
        send_char(hts_pkg::CH_OPEN);
        repeat (BUFFER_CHARS + 2) send_char(rand_tag_char());
        send_char(pick_close());
      end
      default: begin
        // non-hex digit in a packet, odd or even count, then the buffer fills
        tag_session("MemProgC", pick_close());
        send_hex(2 * $urandom_range(0, 4));
        send_char(rand_bad_char());
        send_hex($urandom_range(0, 1));
        send_char(hts_pkg::CH_OPEN);
        repeat (BUFFER_CHARS) send_char(rand_non_open());
      end
    endcase
    repeat (6) send_char(8'($urandom_range(0, 255)));
    s_tvalid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[hex_tag_stream_loader.f]
src/hts_pkg.sv
src/hts_front.sv
src/hts_fifo.sv
src/hts_back.sv
src/hex_tag_stream_loader.sv
tb/hts_checker.sv
tb/tb.sv
